>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file jpp_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define JPP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define JPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg
// Shared types and constants of the joystick packet parser.
// ----------------------------------------------------------------------------
package jpp_pkg;

    localparam int AXIS_LIMIT_DEF   = 8;
    localparam int BUTTON_LIMIT_DEF = 16;

    localparam logic [7:0] HDR_AXIS   = 8'h80;
    localparam logic [7:0] HDR_BUTTON = 8'h81;

    localparam int RES_DATA_W = 32;  // index, axis, value, previous; padded

    typedef enum logic [2:0] {
        KIND_AXIS       = 3'd0,
        KIND_BUTTON     = 3'd1,
        KIND_EMPTY      = 3'd2,
        KIND_AXIS_ERR   = 3'd3,
        KIND_BUTTON_ERR = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         index;
        logic signed [7:0]  axis_value;
        logic [7:0]         button_value;
        logic [7:0]         button_previous;
        logic               packet_done;
    } t_result;

    // Button table access from the parser
    typedef struct packed {
        logic       rd_en;
        logic [3:0] rd_slot;
        logic       wr_en;
        logic [3:0] wr_slot;
        logic [7:0] wr_data;
    } t_btn_req;

endpackage

>>> hdl/jpp_btn_mem.sv
// ----------------------------------------------------------------------------
// jpp_btn_mem
// Button table: one synchronous read port, one write port, per-entry valid.
// ----------------------------------------------------------------------------
module jpp_btn_mem #(
    parameter int BUTTON_LIMIT = jpp_pkg::BUTTON_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jpp_pkg::t_btn_req i_req,
    output logic [7:0]        o_rd_data
);

    localparam int AW = (BUTTON_LIMIT > 1) ? $clog2(BUTTON_LIMIT) : 1;

    logic [7:0]              r_mem [BUTTON_LIMIT];
    logic [BUTTON_LIMIT-1:0] r_valid;
    logic [7:0]              r_rd_data;
    logic                    r_rd_valid;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_slot[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_slot[AW-1:0]];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_slot[AW-1:0]] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_slot[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 8'd0;

endmodule

>>> hdl/jpp_parser.sv
// ----------------------------------------------------------------------------
// jpp_parser
// Byte-level packet state machine; forms one result per request at most.
// ----------------------------------------------------------------------------
module jpp_parser #(
    parameter int AXIS_LIMIT   = jpp_pkg::AXIS_LIMIT_DEF,
    parameter int BUTTON_LIMIT = jpp_pkg::BUTTON_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_prev,
    output jpp_pkg::t_btn_req o_btn_req,
    output jpp_pkg::t_result  o_res,
    output logic              o_res_valid
);

    localparam logic [7:0] AXIS_LIM8 = 8'(AXIS_LIMIT);
    localparam logic [7:0] BTN_LIM8  = 8'(BUTTON_LIMIT);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_AXIS_CNT = 5'b00010,
        ST_AXIS_DAT = 5'b00100,
        ST_BTN_IDX  = 5'b01000,
        ST_BTN_VAL  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_axes_total, n_axes_total;
    logic [3:0] r_axis_pos, n_axis_pos;
    logic [3:0] r_btn_slot, n_btn_slot;
    logic [3:0] w_pos_inc;

    assign w_pos_inc = r_axis_pos + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_axes_total <= 4'd0;
            r_axis_pos   <= 4'd0;
            r_btn_slot   <= 4'd0;
        end else begin
            r_state      <= n_state;
            r_axes_total <= n_axes_total;
            r_axis_pos   <= n_axis_pos;
            r_btn_slot   <= n_btn_slot;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_axes_total = r_axes_total;
        n_axis_pos   = r_axis_pos;
        n_btn_slot   = r_btn_slot;
        o_res        = '0;
        o_res_valid  = 1'b0;
        o_btn_req    = '0;
        if (i_accept) begin
            case (r_state)
                ST_AXIS_CNT: begin
                    if (i_byte >= AXIS_LIM8) begin
                        n_state           = ST_IDLE;
                        o_res.kind        = jpp_pkg::KIND_AXIS_ERR;
                        o_res.packet_done = 1'b1;
                        o_res_valid       = 1'b1;
                    end else if (i_byte == 8'd0) begin
                        n_state           = ST_IDLE;
                        o_res.kind        = jpp_pkg::KIND_EMPTY;
                        o_res.packet_done = 1'b1;
                        o_res_valid       = 1'b1;
                    end else begin
                        n_axes_total = i_byte[3:0];
                        n_axis_pos   = 4'd0;
                        n_state      = ST_AXIS_DAT;
                    end
                end
                ST_AXIS_DAT: begin
                    o_res.kind        = jpp_pkg::KIND_AXIS;
                    o_res.index       = r_axis_pos;
                    o_res.axis_value  = i_byte;
                    o_res.packet_done = (w_pos_inc == r_axes_total);
                    o_res_valid       = 1'b1;
                    n_axis_pos        = w_pos_inc;
                    if (w_pos_inc == r_axes_total) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_BTN_IDX: begin
                    if (i_byte >= BTN_LIM8) begin
                        n_state           = ST_IDLE;
                        o_res.kind        = jpp_pkg::KIND_BUTTON_ERR;
                        o_res.packet_done = 1'b1;
                        o_res_valid       = 1'b1;
                    end else begin
                        // fetch the old value now; it waits in the read register
                        n_btn_slot        = i_byte[3:0];
                        o_btn_req.rd_en   = 1'b1;
                        o_btn_req.rd_slot = i_byte[3:0];
                        n_state           = ST_BTN_VAL;
                    end
                end
                ST_BTN_VAL: begin
                    o_btn_req.wr_en       = 1'b1;
                    o_btn_req.wr_slot     = r_btn_slot;
                    o_btn_req.wr_data     = i_byte;
                    o_res.kind            = jpp_pkg::KIND_BUTTON;
                    o_res.index           = r_btn_slot;
                    o_res.button_value    = i_byte;
                    o_res.button_previous = i_prev;
                    o_res.packet_done     = 1'b1;
                    o_res_valid           = 1'b1;
                    n_state               = ST_IDLE;
                end
                default: begin
                    if (i_byte == jpp_pkg::HDR_AXIS) begin
                        n_state = ST_AXIS_CNT;
                    end else if (i_byte == jpp_pkg::HDR_BUTTON) begin
                        n_state = ST_BTN_IDX;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/jpp_out_skid.sv
// ----------------------------------------------------------------------------
// jpp_out_skid
// Output register with one skid entry; input ready does not depend on
// output ready.
// ----------------------------------------------------------------------------
module jpp_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jpp_pkg::t_result i_res,
    input  logic             i_m_ready,
    output logic             o_s_ready,
    output logic             o_m_valid,
    output jpp_pkg::t_result o_m_res
);

    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    jpp_pkg::t_result r_out, n_out;
    jpp_pkg::t_result r_skid, n_skid;
    logic             w_pop;

    assign w_pop     = r_out_valid & i_m_ready;
    assign o_s_ready = ~r_skid_valid;
    assign o_m_valid = r_out_valid;
    assign o_m_res   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

>>> hdl/joystick_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// joystick_packet_parser_unit: byte-serial joystick packet parser
// Results are registered in the output register, or the skid entry on a stall.
// Throughput: 1 request per cycle; input stalls only while two results wait.
// Reset (sync, active low): idle parser, button table reads zero, buffer empty.
// ----------------------------------------------------------------------------
// Packet formats:
//   0x80, count, count axis bytes -> one axis result per byte
//   0x81, index, value            -> one button result (new and old value)
// The button table lives in a synchronous RAM. Its read is issued when the
// index byte is accepted, so the old value sits in the read register when the
// value byte arrives; the write goes out in that same cycle. The next read of
// a button packet comes at least two requests after a write, and the RAM
// already holds the new value then, so no forwarding path is needed.
// Every request needs at most one table read and one table write, so the
// table never limits the rate. The output register plus one skid entry keeps
// the input ready from depending on the master-side ready. No clearing pass
// after reset; per-entry valid bits make unwritten buttons read as zero.
// ----------------------------------------------------------------------------
module joystick_packet_parser_unit #(
    parameter int AXIS_LIMIT   = jpp_pkg::AXIS_LIMIT_DEF,   // 2..16
    parameter int BUTTON_LIMIT = jpp_pkg::BUTTON_LIMIT_DEF  // 2..16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] rx_byte
    // result side
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [3:0] index, [11:4] axis_value, [19:12] button_value,
    // [27:20] button_previous, [31:28] zero
    output logic [jpp_pkg::RES_DATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]                    o_m_axis_tuser,   // [2:0] kind
    output logic                          o_m_axis_tlast    // packet_done
);

    logic              w_accept;
    logic [7:0]        w_prev;
    logic              w_res_valid;
    jpp_pkg::t_result  w_res;
    jpp_pkg::t_result  w_out;
    jpp_pkg::t_btn_req w_btn_req;

    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;

    // packet state machine
    jpp_parser #(
        .AXIS_LIMIT   (AXIS_LIMIT),
        .BUTTON_LIMIT (BUTTON_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_axis_tdata),
        .i_prev      (w_prev),
        .o_btn_req   (w_btn_req),
        .o_res       (w_res),
        .o_res_valid (w_res_valid)
    );

    // button table RAM
    jpp_btn_mem #(
        .BUTTON_LIMIT (BUTTON_LIMIT)
    ) u_btn_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_btn_req),
        .o_rd_data (w_prev)
    );

    // output register plus skid entry
    jpp_out_skid u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_res_valid),
        .i_res     (w_res),
        .i_m_ready (i_m_axis_tready),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_res   (w_out)
    );

    assign o_m_axis_tdata = {4'd0, w_out.button_previous, w_out.button_value,
                             w_out.axis_value, w_out.index};
    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tlast = w_out.packet_done;

endmodule

>>> hdl/jpp_checker.sv
// ----------------------------------------------------------------------------
// jpp_checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jpp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [jpp_pkg::RES_DATA_W-1:0] o_m_axis_tdata,
    input logic [2:0]                     o_m_axis_tuser,
    input logic                           o_m_axis_tlast
);

    logic w_is_axis;
    logic w_is_btn;

    assign w_is_axis = (o_m_axis_tuser == jpp_pkg::KIND_AXIS);
    assign w_is_btn  = (o_m_axis_tuser == jpp_pkg::KIND_BUTTON);

    // every kind but an axis sample closes its packet
    `JPP_ASSERT(a_last_non_axis, i_clk, i_rst_n, !o_m_axis_tvalid || w_is_axis || o_m_axis_tlast, "non-axis result without tlast")

    // axis value only on axis samples
    `JPP_ASSERT(a_axis_field, i_clk, i_rst_n, !o_m_axis_tvalid || w_is_axis || (o_m_axis_tdata[11:4] == 8'd0), "axis value on other kind")

    // button fields and index only on button updates (index also on axis)
    `JPP_ASSERT(a_btn_fields, i_clk, i_rst_n, !o_m_axis_tvalid || w_is_btn || ((o_m_axis_tdata[27:12] == 16'd0) && (w_is_axis || (o_m_axis_tdata[3:0] == 4'd0))), "button fields on other kind")

    // stalled result is held
    `JPP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind joystick_packet_parser_unit jpp_checker u_jpp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
